@@ rtl/ptrt_pkg.sv @@
package ptrt_pkg;

  // Width of every tick counter (period, countdown, start delay).
  localparam int unsigned TickW = 16;

  // At most this many results leave one dispatch command.
  localparam int unsigned MaxResults = 8;
  localparam int unsigned ResCntW    = 3;

  // Command codes.
  localparam logic [2:0] CMD_TICK       = 3'd0;
  localparam logic [2:0] CMD_ADD        = 3'd1;
  localparam logic [2:0] CMD_ENABLE     = 3'd2;
  localparam logic [2:0] CMD_DISABLE    = 3'd3;
  localparam logic [2:0] CMD_SET_PERIOD = 3'd4;
  localparam logic [2:0] CMD_DISPATCH   = 3'd5;

  // Status codes.
  localparam logic [2:0] STAT_OK          = 3'd0;
  localparam logic [2:0] STAT_FULL        = 3'd1;
  localparam logic [2:0] STAT_NO_TASK     = 3'd2;
  localparam logic [2:0] STAT_EMPTY       = 3'd3;
  localparam logic [2:0] STAT_ZERO_PERIOD = 3'd4;

  typedef struct packed {
    logic [2:0]       cmd;
    logic [2:0]       task_index;
    logic [TickW-1:0] delay_ticks;
    logic [TickW-1:0] period_ticks;
  } in_t;

  typedef struct packed {
    logic [2:0] status_code;
    logic [2:0] slot_number;
    logic       slot_valid;
    logic       last_result;
  } out_t;

endpackage

@@ rtl/periodic_task_ready_table_unit.sv @@
// Channel | Direction | Handshake                 | Payload
// in      | to unit   | in_valid_i / in_stall_o   | in_data_i  (ptrt_pkg::in_t)
// out     | from unit | out_valid_o / out_stall_i | out_data_o (ptrt_pkg::out_t)
//
// Add, enable, disable, set period and unknown commands answer straight from idle.
// A tick walks the occupied slots through the timer memory, one slot read per
// cycle with each write back in the cycle after its read, then returns a result.
// A dispatch scans one slot per cycle; each served slot takes a period read,
// then a reload and result, and the reload waits while the out side stalls.
// Reset clears the slot count and the enable and ready flags; the two memories
// are not cleared, since an entry is only read after an add has written it.
module periodic_task_ready_table_unit #(
  parameter int unsigned TASK_SLOTS = 8
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  ptrt_pkg::in_t  in_data_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output ptrt_pkg::out_t out_data_o
);

  localparam int unsigned IdxW   = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
  localparam int unsigned CntW   = $clog2(TASK_SLOTS + 1);
  localparam int unsigned TimerW = 2 * ptrt_pkg::TickW;

  // The sequencer is a one-hot state machine.
  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_TICK   = 5'b00010,
    ST_TFIN   = 5'b00100,
    ST_DSCAN  = 5'b01000,
    ST_DWRITE = 5'b10000
  } state_e;

  state_e state_q, state_d;

  logic [CntW-1:0]       used_count_q, used_count_d;
  logic [TASK_SLOTS-1:0] enabled_q, enabled_d;
  logic [TASK_SLOTS-1:0] ready_q, ready_d;
  logic [TASK_SLOTS-1:0] used_mask;

  // Slots still to be served by the running dispatch.
  logic [TASK_SLOTS-1:0] run_q, run_d;
  logic [TASK_SLOTS-1:0] run_rest;

  // Walk pointer: read index during a tick, scan index during a dispatch.
  logic [IdxW-1:0] ptr_q, ptr_d;
  logic [ptrt_pkg::ResCntW-1:0] served_q, served_d;

  // Write-back stage of the tick walk.
  logic            wb_vld_q, wb_vld_d;
  logic [IdxW-1:0] wb_idx_q, wb_idx_d;

  // Output register.
  logic           out_vld_q, out_vld_d;
  ptrt_pkg::out_t out_q, out_d;
  logic           out_load;
  logic           out_free;

  logic in_fire;

  // Timer memory holds {start delay, countdown}; period memory holds the period.
  logic                      tm_we, tm_re;
  logic [IdxW-1:0]           tm_waddr, tm_raddr;
  logic [TimerW-1:0]         tm_wdata, tm_rdata;
  logic                      pm_we, pm_re;
  logic [IdxW-1:0]           pm_waddr, pm_raddr;
  logic [ptrt_pkg::TickW-1:0] pm_wdata, pm_rdata;

  logic [ptrt_pkg::TickW-1:0] wb_delay, wb_count, wb_count_dec;

  logic [IdxW-1:0] cmd_idx;
  logic [IdxW-1:0] add_idx;
  logic            idx_occupied;

  ptrt_ram #(
    .Width (TimerW),
    .Depth (TASK_SLOTS),
    .AddrW (IdxW)
  ) u_timer_ram (
    .clk_i   (clk_i),
    .we_i    (tm_we),
    .waddr_i (tm_waddr),
    .wdata_i (tm_wdata),
    .re_i    (tm_re),
    .raddr_i (tm_raddr),
    .rdata_o (tm_rdata)
  );

  ptrt_ram #(
    .Width (ptrt_pkg::TickW),
    .Depth (TASK_SLOTS),
    .AddrW (IdxW)
  ) u_period_ram (
    .clk_i   (clk_i),
    .we_i    (pm_we),
    .waddr_i (pm_waddr),
    .wdata_i (pm_wdata),
    .re_i    (pm_re),
    .raddr_i (pm_raddr),
    .rdata_o (pm_rdata)
  );

  // Slots fill in index order and are never freed, so a slot is occupied
  // exactly when its index is below the slot count.
  always_comb begin
    for (int i = 0; i < TASK_SLOTS; i++) begin
      used_mask[i] = (8'(i) < 8'(used_count_q));
    end
  end

  assign out_free   = !out_vld_q || !out_stall_i;
  assign in_stall_o = !((state_q == ST_IDLE) && out_free);
  assign in_fire    = in_valid_i && !in_stall_o;

  assign cmd_idx      = IdxW'(in_data_i.task_index);
  assign add_idx      = IdxW'(used_count_q);
  assign idx_occupied = (8'(in_data_i.task_index) < 8'(used_count_q));

  // Tick write-back arithmetic on the word read in the cycle before.
  assign wb_delay     = tm_rdata[TimerW-1:ptrt_pkg::TickW];
  assign wb_count     = tm_rdata[ptrt_pkg::TickW-1:0];
  assign wb_count_dec = wb_count - ptrt_pkg::TickW'(1);

  // Served slot with its bit cleared; empty means this result is the last one.
  always_comb begin
    run_rest        = run_q;
    run_rest[ptr_q] = 1'b0;
  end

  always_comb begin
    state_d      = state_q;
    used_count_d = used_count_q;
    enabled_d    = enabled_q;
    ready_d      = ready_q;
    run_d        = run_q;
    ptr_d        = ptr_q;
    served_d     = served_q;
    wb_vld_d     = 1'b0;
    wb_idx_d     = wb_idx_q;
    out_load     = 1'b0;
    out_d        = out_q;

    tm_we    = 1'b0;
    tm_waddr = wb_idx_q;
    tm_wdata = tm_rdata;
    tm_re    = 1'b0;
    tm_raddr = ptr_q;
    pm_we    = 1'b0;
    pm_waddr = cmd_idx;
    pm_wdata = in_data_i.period_ticks;
    pm_re    = 1'b0;
    pm_raddr = ptr_q;

    // The tick write-back runs whenever its stage holds a slot.
    if (wb_vld_q) begin
      tm_we    = 1'b1;
      tm_waddr = wb_idx_q;
      if (wb_delay != '0) begin
        tm_wdata = {wb_delay - ptrt_pkg::TickW'(1), wb_count};
      end else begin
        tm_wdata = {wb_delay, wb_count_dec};
        if (wb_count_dec == '0) begin
          ready_d[wb_idx_q] = 1'b1;
        end
      end
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          out_d.status_code = ptrt_pkg::STAT_OK;
          out_d.slot_number = '0;
          out_d.slot_valid  = 1'b0;
          out_d.last_result = 1'b1;
          out_load          = 1'b1;
          unique case (in_data_i.cmd) inside
            ptrt_pkg::CMD_TICK: begin
              if (used_count_q != '0) begin
                out_load = 1'b0;
                ptr_d    = '0;
                state_d  = ST_TICK;
              end
            end
            ptrt_pkg::CMD_ADD: begin
              if (in_data_i.period_ticks == '0) begin
                out_d.status_code = ptrt_pkg::STAT_ZERO_PERIOD;
              end else if (used_count_q == CntW'(TASK_SLOTS)) begin
                out_d.status_code = ptrt_pkg::STAT_FULL;
              end else begin
                tm_we              = 1'b1;
                tm_waddr           = add_idx;
                tm_wdata           = {in_data_i.delay_ticks, in_data_i.period_ticks};
                pm_we              = 1'b1;
                pm_waddr           = add_idx;
                enabled_d[add_idx] = 1'b1;
                ready_d[add_idx]   = 1'b0;
                used_count_d       = used_count_q + CntW'(1);
                out_d.slot_number  = 3'(add_idx);
                out_d.slot_valid   = 1'b1;
              end
            end
            ptrt_pkg::CMD_ENABLE, ptrt_pkg::CMD_DISABLE, ptrt_pkg::CMD_SET_PERIOD: begin
              if (used_count_q == '0) begin
                out_d.status_code = ptrt_pkg::STAT_EMPTY;
              end else if (!idx_occupied) begin
                out_d.status_code = ptrt_pkg::STAT_NO_TASK;
              end else if (in_data_i.cmd == ptrt_pkg::CMD_ENABLE) begin
                enabled_d[cmd_idx] = 1'b1;
              end else if (in_data_i.cmd == ptrt_pkg::CMD_DISABLE) begin
                enabled_d[cmd_idx] = 1'b0;
              end else if (in_data_i.period_ticks == '0) begin
                out_d.status_code = ptrt_pkg::STAT_ZERO_PERIOD;
              end else begin
                // The new period waits in memory for the next reload.
                pm_we = 1'b1;
              end
            end
            ptrt_pkg::CMD_DISPATCH: begin
              run_d    = used_mask & enabled_q & ready_q;
              ptr_d    = '0;
              served_d = '0;
              if ((used_mask & enabled_q & ready_q) != '0) begin
                out_load = 1'b0;
                state_d  = ST_DSCAN;
              end
            end
            default: begin
            end
          endcase
        end
      end

      ST_TICK: begin
        tm_re    = 1'b1;
        tm_raddr = ptr_q;
        wb_vld_d = 1'b1;
        wb_idx_d = ptr_q;
        if ((CntW'(ptr_q) + CntW'(1)) == used_count_q) begin
          state_d = ST_TFIN;
        end else begin
          ptr_d = ptr_q + IdxW'(1);
        end
      end

      ST_TFIN: begin
        // The last write-back happens this cycle; the output is known empty.
        out_d.status_code = ptrt_pkg::STAT_OK;
        out_d.slot_number = '0;
        out_d.slot_valid  = 1'b0;
        out_d.last_result = 1'b1;
        out_load          = 1'b1;
        state_d           = ST_IDLE;
      end

      ST_DSCAN: begin
        if (run_q[ptr_q]) begin
          pm_re    = 1'b1;
          pm_raddr = ptr_q;
          state_d  = ST_DWRITE;
        end else begin
          ptr_d = ptr_q + IdxW'(1);
        end
      end

      ST_DWRITE: begin
        if (out_free) begin
          // A ready slot has finished its start delay, so the delay stays zero.
          tm_we             = 1'b1;
          tm_waddr          = ptr_q;
          tm_wdata          = {ptrt_pkg::TickW'(0), pm_rdata};
          ready_d[ptr_q]    = 1'b0;
          run_d             = run_rest;
          served_d          = served_q + ptrt_pkg::ResCntW'(1);
          out_d.status_code = ptrt_pkg::STAT_OK;
          out_d.slot_number = 3'(ptr_q);
          out_d.slot_valid  = 1'b1;
          out_d.last_result = (run_rest == '0) ||
                              (served_q == ptrt_pkg::ResCntW'(ptrt_pkg::MaxResults - 1));
          out_load          = 1'b1;
          if (out_d.last_result) begin
            state_d = ST_IDLE;
          end else begin
            ptr_d   = ptr_q + IdxW'(1);
            state_d = ST_DSCAN;
          end
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase

    if (out_load) begin
      out_vld_d = 1'b1;
    end else if (out_stall_i) begin
      out_vld_d = out_vld_q;
    end else begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      used_count_q <= '0;
      enabled_q    <= '0;
      ready_q      <= '0;
      run_q        <= '0;
      ptr_q        <= '0;
      served_q     <= '0;
      wb_vld_q     <= 1'b0;
      out_vld_q    <= 1'b0;
    end else begin
      state_q      <= state_d;
      used_count_q <= used_count_d;
      enabled_q    <= enabled_d;
      ready_q      <= ready_d;
      run_q        <= run_d;
      ptr_q        <= ptr_d;
      served_q     <= served_d;
      wb_vld_q     <= wb_vld_d;
      out_vld_q    <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    wb_idx_q <= wb_idx_d;
    if (out_load) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

endmodule

@@ rtl/ptrt_ram.sv @@
module ptrt_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 8,
  parameter int unsigned AddrW = 3
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Read data holds until the next read.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/ptrt_checker.sv @@
module ptrt_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           in_valid_i,
  input logic           in_stall_o,
  input ptrt_pkg::in_t  in_data_i,
  input logic           out_valid_o,
  input logic           out_stall_i,
  input ptrt_pkg::out_t out_data_o
);

  // A stalled command beat stays and keeps its payload.
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_stall_o |=> in_valid_i && $stable(in_data_i))
    else $error("command beat changed while stalled");

  // A stalled result beat stays and keeps its payload.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("result beat changed while stalled");

  // A beat without a slot carries slot number zero.
  a_slot_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.slot_valid |-> out_data_o.slot_number == 3'd0)
    else $error("slot number set on a beat without a slot");

  // Every refusal is a single final beat without a slot.
  a_refusal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.status_code != ptrt_pkg::STAT_OK
    |-> out_data_o.last_result && !out_data_o.slot_valid)
    else $error("refusal beat carries a slot or is not final");

  // Every status code is one of the defined codes.
  a_status_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.status_code == ptrt_pkg::STAT_OK ||
                    out_data_o.status_code == ptrt_pkg::STAT_FULL ||
                    out_data_o.status_code == ptrt_pkg::STAT_NO_TASK ||
                    out_data_o.status_code == ptrt_pkg::STAT_EMPTY ||
                    out_data_o.status_code == ptrt_pkg::STAT_ZERO_PERIOD)
    else $error("undefined status code");

endmodule

bind periodic_task_ready_table_unit ptrt_checker u_ptrt_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .in_data_i   (in_data_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);

@@ tb/ptrt_table_checker.sv @@
module ptrt_table_checker (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  input  logic           in_stall_i,
  input  ptrt_pkg::in_t  in_data_i,
  input  logic           out_valid_i,
  input  logic           out_stall_i,
  input  ptrt_pkg::out_t out_data_i,
  output int             fail_count_o,
  output int             pending_o,
  output int             checked_o
);
  import ptrt_pkg::*;

  localparam int unsigned Slots = 8;

  // Shadow copy of the task table.
  bit               used_q    [Slots];
  bit               enabled_q [Slots];
  bit               ready_q   [Slots];
  logic [TickW-1:0] period_q  [Slots];
  logic [TickW-1:0] count_q   [Slots];
  logic [TickW-1:0] delay_q   [Slots];
  int               used_total;

  out_t expected_status_q[$];
  int   mismatches;
  int   beats_checked;

  function automatic void push_status(logic [2:0] code, logic [2:0] slot, logic valid,
                                      logic last);
    out_t beat;
    beat.status_code = code;
    beat.slot_number = slot;
    beat.slot_valid  = valid;
    beat.last_result = last;
    expected_status_q.push_back(beat);
  endfunction

  // Applies one command to the shadow table and queues the status beats it causes.
  function automatic void step_task_table(in_t cmd_beat);
    logic [2:0] code;
    int         served;
    int         slot;
    code   = STAT_OK;
    served = 0;
    slot   = -1;
    case (cmd_beat.cmd)
      CMD_TICK: begin
        for (int i = 0; i < Slots; i++) begin
          if (used_q[i]) begin
            if (delay_q[i] != '0) begin
              delay_q[i] = delay_q[i] - 1'b1;
            end else begin
              count_q[i] = count_q[i] - 1'b1;
              if (count_q[i] == '0) ready_q[i] = 1'b1;
            end
          end
        end
        push_status(STAT_OK, 3'd0, 1'b0, 1'b1);
      end
      CMD_ADD: begin
        if (cmd_beat.period_ticks == '0) begin
          code = STAT_ZERO_PERIOD;
        end else if (used_total >= Slots) begin
          code = STAT_FULL;
        end else begin
          for (int i = 0; i < Slots; i++) begin
            if (!used_q[i] && slot < 0) slot = i;
          end
          used_q[slot]    = 1'b1;
          enabled_q[slot] = 1'b1;
          ready_q[slot]   = 1'b0;
          period_q[slot]  = cmd_beat.period_ticks;
          count_q[slot]   = cmd_beat.period_ticks;
          delay_q[slot]   = cmd_beat.delay_ticks;
          used_total++;
        end
        if (slot >= 0) push_status(STAT_OK, 3'(slot), 1'b1, 1'b1);
        else push_status(code, 3'd0, 1'b0, 1'b1);
      end
      CMD_ENABLE, CMD_DISABLE, CMD_SET_PERIOD: begin
        if (used_total == 0) begin
          code = STAT_EMPTY;
        end else if (int'(cmd_beat.task_index) >= Slots || !used_q[cmd_beat.task_index]) begin
          code = STAT_NO_TASK;
        end else if (cmd_beat.cmd == CMD_ENABLE) begin
          enabled_q[cmd_beat.task_index] = 1'b1;
        end else if (cmd_beat.cmd == CMD_DISABLE) begin
          enabled_q[cmd_beat.task_index] = 1'b0;
        end else if (cmd_beat.period_ticks == '0) begin
          code = STAT_ZERO_PERIOD;
        end else begin
          // The running countdown keeps going; the new period waits for the reload.
          period_q[cmd_beat.task_index] = cmd_beat.period_ticks;
        end
        push_status(code, 3'd0, 1'b0, 1'b1);
      end
      CMD_DISPATCH: begin
        for (int i = 0; i < Slots; i++) begin
          if (served < MaxResults && used_q[i] && ready_q[i] && enabled_q[i]) begin
            ready_q[i] = 1'b0;
            count_q[i] = period_q[i];
            push_status(STAT_OK, 3'(i), 1'b1, 1'b0);
            served++;
          end
        end
        if (served == 0) push_status(STAT_OK, 3'd0, 1'b0, 1'b1);
        else expected_status_q[expected_status_q.size() - 1].last_result = 1'b1;
      end
      default: push_status(STAT_OK, 3'd0, 1'b0, 1'b1);
    endcase
  endfunction

  function automatic void check_field(string name, logic [2:0] want, logic [2:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  // Outputs are updated with nonblocking assignments so that the stimulus side
  // always sees the value from before the current edge.
  always @(posedge clk_i) begin
    out_t want;
    if (!rst_ni) begin
      for (int i = 0; i < Slots; i++) begin
        used_q[i]    = 1'b0;
        enabled_q[i] = 1'b0;
        ready_q[i]   = 1'b0;
      end
      used_total = 0;
      expected_status_q.delete();
    end else begin
      // A result beat can never belong to a command accepted at the same edge,
      // so the output side is checked before the new command is predicted.
      if (out_valid_i && !out_stall_i) begin
        if (expected_status_q.size() == 0) begin
          $error("status beat with nothing expected: status_code %0d slot_number %0d",
                 out_data_i.status_code, out_data_i.slot_number);
          mismatches++;
        end else begin
          want = expected_status_q.pop_front();
          check_field("status_code", want.status_code, out_data_i.status_code);
          check_field("slot_number", want.slot_number, out_data_i.slot_number);
          check_field("slot_valid", 3'(want.slot_valid), 3'(out_data_i.slot_valid));
          check_field("last_result", 3'(want.last_result), 3'(out_data_i.last_result));
          beats_checked++;
        end
      end
      if (in_valid_i && !in_stall_i) step_task_table(in_data_i);
    end
    pending_o    <= expected_status_q.size();
    fail_count_o <= mismatches;
    checked_o    <= beats_checked;
  end

endmodule

@@ tb/tb_periodic_task_ready_table_unit.sv @@
module tb_periodic_task_ready_table_unit;
  import ptrt_pkg::*;

  // Command codes 6 and 7 are not defined by the block and must be ignored.
  localparam logic [2:0] CMD_SPARE_A = 3'd6;
  localparam logic [2:0] CMD_SPARE_B = 3'd7;

  localparam int RandomBeats = 500;
  // No acceptance on either channel for this many cycles means the block hung.
  // The slowest legal stretch is a long sender gap or a long receiver stall
  // on top of a dispatch walking all eight slots.
  localparam int HangLimit   = 4000;

  logic clk_i       = 1'b0;
  logic rst_ni      = 1'b0;
  logic in_valid_i  = 1'b0;
  logic out_stall_i = 1'b0;
  in_t  in_data_i   = '0;
  logic in_stall_o;
  logic out_valid_o;
  out_t out_data_o;

  int fail_count;
  int pending_beats;
  int checked_beats;
  int commands_sent;
  int directed_sent;
  int idle_cycles;

  // Receiver state: a stall burst in progress, or a calm stretch without stalls.
  int stall_left;
  int calm_left;
  int stall_pick;

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  periodic_task_ready_table_unit u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  ptrt_table_checker u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_i  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_i (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_i  (out_data_o),
    .fail_count_o(fail_count),
    .pending_o   (pending_beats),
    .checked_o   (checked_beats)
  );

  // Receiver back-pressure. Most cycles take the beat; short stalls are common,
  // long ones rare, and now and then a calm stretch lets results drain freely.
  always @(posedge clk_i) begin
    if (stall_left != 0) begin
      stall_left  <= stall_left - 1;
      out_stall_i <= 1'b1;
    end else if (calm_left != 0) begin
      calm_left   <= calm_left - 1;
      out_stall_i <= 1'b0;
    end else begin
      stall_pick = $urandom_range(0, 99);
      if (stall_pick < 60) begin
        out_stall_i <= 1'b0;
      end else if (stall_pick < 85) begin
        stall_left  <= $urandom_range(0, 2);
        out_stall_i <= 1'b1;
      end else if (stall_pick < 93) begin
        stall_left  <= $urandom_range(8, 40);
        out_stall_i <= 1'b1;
      end else begin
        calm_left   <= $urandom_range(20, 80);
        out_stall_i <= 1'b0;
      end
    end
  end

  // Hang detection: count cycles in which neither channel moves a beat.
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= HangLimit) begin
      $display("FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Sender gap length: mostly back to back, sometimes short, rarely long.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Presents one command beat and returns at the edge where it is accepted.
  // The payload stays put while the block stalls.
  task automatic send_beat(input in_t cmd_beat);
    in_data_i  <= cmd_beat;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    commands_sent++;
  endtask

  task automatic hold_off(input int gap);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Stops sending until every predicted status beat has come out. The first
  // edge is always taken so that the checker has seen the last accepted command.
  task automatic drain_results();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending_beats != 0);
  endtask

  task automatic send_cmd(input logic [2:0] cmd, input logic [2:0] index,
                          input logic [TickW-1:0] delay, input logic [TickW-1:0] period);
    in_t cmd_beat;
    cmd_beat.cmd          = cmd;
    cmd_beat.task_index   = index;
    cmd_beat.delay_ticks  = delay;
    cmd_beat.period_ticks = period;
    send_beat(cmd_beat);
    hold_off(pick_gap());
  endtask

  initial begin
    in_t cmd_beat;
    int  r;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Everything on an empty table: tick and dispatch report no slot, the slot
    // commands report an empty table, and spare command codes are ignored.
    send_cmd(CMD_TICK, 3'd0, 16'd0, 16'd0);
    send_cmd(CMD_DISPATCH, 3'd0, 16'd0, 16'd0);
    send_cmd(CMD_ENABLE, 3'd0, 16'd0, 16'd0);
    send_cmd(CMD_SET_PERIOD, 3'd3, 16'd0, 16'd5);
    send_cmd(CMD_SPARE_A, 3'd7, 16'hFFFF, 16'hFFFF);
    send_cmd(CMD_SPARE_B, 3'd0, 16'd0, 16'd0);

    // A zero period is refused before anything else; then the first tasks go in.
    // Slot 1 takes both field maxima and never becomes ready within the run.
    send_cmd(CMD_ADD, 3'd0, 16'd0, 16'd0);
    send_cmd(CMD_ADD, 3'd0, 16'd0, 16'd1);
    send_cmd(CMD_DISABLE, 3'd5, 16'd0, 16'd1);
    send_cmd(CMD_SET_PERIOD, 3'd0, 16'd0, 16'd0);
    send_cmd(CMD_ADD, 3'd0, 16'hFFFF, 16'hFFFF);
    send_cmd(CMD_ADD, 3'd0, 16'd1, 16'd2);

    // Slot 0 reaches zero on the first tick and wraps on the second while it
    // stays ready; slot 2 spends the first tick on its start delay.
    send_cmd(CMD_TICK, 3'd0, 16'd0, 16'd0);
    send_cmd(CMD_TICK, 3'd0, 16'd0, 16'd0);
    send_cmd(CMD_DISPATCH, 3'd0, 16'd0, 16'd0);

    // A new period for slot 2 must wait for its next reload, and a disabled
    // slot that turns ready is skipped by dispatch but keeps its ready flag.
    send_cmd(CMD_SET_PERIOD, 3'd2, 16'd0, 16'd3);
    send_cmd(CMD_DISABLE, 3'd0, 16'd0, 16'd0);
    send_cmd(CMD_TICK, 3'd0, 16'd0, 16'd0);
    send_cmd(CMD_DISPATCH, 3'd0, 16'd0, 16'd0);
    send_cmd(CMD_ENABLE, 3'd0, 16'd0, 16'd0);

    // Fill the table, then show that the zero-period check wins over full.
    for (int k = 3; k < 8; k++) send_cmd(CMD_ADD, 3'd0, 16'(k - 3), 16'(k - 1));
    send_cmd(CMD_ADD, 3'd0, 16'd0, 16'd4);
    send_cmd(CMD_ADD, 3'd0, 16'd0, 16'd0);
    directed_sent = commands_sent;
    drain_results();

    // Random commands against the full table. Ticks and dispatches dominate so
    // that many slots become ready; most periods are short for the same reason.
    // Every third stretch of 64 beats runs back to back without sender gaps.
    for (int n = 0; n < RandomBeats; n++) begin
      r = $urandom_range(0, 99);
      if (r < 38) cmd_beat.cmd = CMD_TICK;
      else if (r < 58) cmd_beat.cmd = CMD_DISPATCH;
      else if (r < 68) cmd_beat.cmd = CMD_ENABLE;
      else if (r < 76) cmd_beat.cmd = CMD_DISABLE;
      else if (r < 88) cmd_beat.cmd = CMD_SET_PERIOD;
      else if (r < 94) cmd_beat.cmd = CMD_ADD;
      else if (r < 97) cmd_beat.cmd = CMD_SPARE_A;
      else cmd_beat.cmd = CMD_SPARE_B;
      cmd_beat.task_index  = 3'($urandom_range(0, 7));
      cmd_beat.delay_ticks = 16'($urandom());
      r = $urandom_range(0, 99);
      if (r < 8) cmd_beat.period_ticks = '0;
      else if (r < 25) cmd_beat.period_ticks = 16'($urandom());
      else cmd_beat.period_ticks = 16'($urandom_range(1, 12));
      send_beat(cmd_beat);
      if (n == RandomBeats / 2) drain_results();
      else if ((n / 64) % 3 != 1) hold_off(pick_gap());
    end

    drain_results();
    repeat (30) @(posedge clk_i);

    $display("Covered %0d commands (%0d directed, rest random) and checked %0d status beats.",
             commands_sent, directed_sent, checked_beats);
    if (fail_count == 0 && pending_beats == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/ptrt_pkg.sv
rtl/ptrt_ram.sv
rtl/periodic_task_ready_table_unit.sv
rtl/ptrt_checker.sv
tb/ptrt_table_checker.sv
tb/tb_periodic_task_ready_table_unit.sv
